// ===== src/sul_pkg.sv =====
// Shared types and constants of the sorted unique list unit.
// No dependencies; used by sul_cell, sorted_unique_list_unit and the testbench.
package sul_pkg;

	localparam int CAPACITY = 32;
	localparam int VAL_W    = 32;
	localparam int SIZE_W   = 6;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	typedef struct packed {
		logic                    ins;
		logic                    del;
		logic                    load;
		logic                    shift;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] val;
		logic                    vld;
		logic                    lt;
	} link_t;

endpackage

// ===== src/sorted_unique_list_unit.sv =====
// Sorted unique list unit: insert/delete of distinct signed values, then a
// readout of the whole list. Depends on sul_pkg and sul_cell.
// Latency: the update completes in the accept cycle; the first result beat
// is valid the next cycle. The readout shift line gives one element a beat;
// a new operation is taken only after the last beat is accepted.
// Reset: asynchronous, active low; the list is empty after reset.
module sorted_unique_list_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [0:0]  s_tuser,  // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [5:0] list_size, [37:6] element, [39:38] zero
	output logic [1:0]  m_tuser,  // [0] element_valid, [1] overflow
	output logic        m_tlast
);
	import sul_pkg::*;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q, cnt_d, rem_q;
	logic                  ovf_q, ev_q;
	cell_ctl_t             ctl;
	link_t                 lnk [CAPACITY+2];
	logic [CAPACITY-1:0]   eqv;
	logic signed [VAL_W-1:0] shr [CAPACITY+1];
	logic                  s_acc, m_acc, present, full, ovf_d, is_last;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;
	assign present  = |eqv;
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign ovf_d    = !s_tuser[0] && !present && full;
	assign is_last  = (rem_q == CNT_W'(1));

	assign ctl.ins   = s_acc && !s_tuser[0] && !present && !full;
	assign ctl.del   = s_acc && s_tuser[0] && present;
	assign ctl.load  = s_acc;
	assign ctl.shift = m_acc;
	assign ctl.value = s_tdata;

	always_comb begin
		cnt_d = cnt_q;
		if (ctl.ins) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (ctl.del) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	// chain boundaries: virtual minus-infinity on the left, empty slot on the right
	assign lnk[0].val          = '0;
	assign lnk[0].vld          = 1'b1;
	assign lnk[0].lt           = 1'b1;
	assign lnk[CAPACITY+1].val = '0;
	assign lnk[CAPACITY+1].vld = 1'b0;
	assign lnk[CAPACITY+1].lt  = 1'b0;
	assign shr[CAPACITY]       = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sul_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.lft      (lnk[i]),
			.rgt      (lnk[i+2]),
			.shr_next (shr[i+1]),
			.me       (lnk[i+1]),
			.eq       (eqv[i]),
			.shr      (shr[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			ovf_q   <= 1'b0;
			ev_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_EMIT;
						cnt_q   <= cnt_d;
						rem_q   <= (cnt_d == '0) ? CNT_W'(1) : cnt_d;
						ovf_q   <= ovf_d;
						ev_q    <= (cnt_d != '0);
					end
				end
				ST_EMIT: begin
					if (m_acc) begin
						rem_q <= rem_q - CNT_W'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tlast  = is_last;
	assign m_tdata  = {2'b00, (ev_q ? shr[0] : {VAL_W{1'b0}}), SIZE_W'(cnt_q)};
	assign m_tuser  = {ovf_q, ev_q};

endmodule

// ===== src/sul_cell.sv =====
// One cell of the sorted list chain: a stored value with its valid flag, plus
// one stage of the readout shift line. Depends on sul_pkg.
module sul_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sul_pkg::cell_ctl_t             ctl,
	input  sul_pkg::link_t                 lft,
	input  sul_pkg::link_t                 rgt,
	input  logic signed [sul_pkg::VAL_W-1:0] shr_next,
	output sul_pkg::link_t                 me,
	output logic                           eq,
	output logic signed [sul_pkg::VAL_W-1:0] shr
);
	import sul_pkg::*;

	logic signed [VAL_W-1:0] val_q, val_d, shr_q;
	logic                    vld_q, vld_d, lt;

	assign lt = vld_q && (val_q < ctl.value);
	assign eq = vld_q && (val_q == ctl.value);

	always_comb begin
		val_d = val_q;
		vld_d = vld_q;
		if (ctl.ins && !lt) begin
			val_d = lft.lt ? ctl.value : lft.val;
			vld_d = lft.lt ? 1'b1 : lft.vld;
		end else if (ctl.del && !lt) begin
			val_d = rgt.val;
			vld_d = rgt.vld;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		if (ctl.load) begin
			shr_q <= val_d;
		end else if (ctl.shift) begin
			shr_q <= shr_next;
		end
	end

	assign me.val = val_q;
	assign me.vld = vld_q;
	assign me.lt  = lt;
	assign shr    = shr_q;

endmodule

// ===== src/sul_checker.sv =====
// Port-level checker for sorted_unique_list_unit, attached by bind.
// Depends on the top level's port list only.
module sul_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !m_tvalid)
		else $error("input taken while results pending");

	a_answer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after operation");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
			m_tlast && (m_tdata[5:0] == 6'd0) && (m_tdata[37:6] == 32'd0))
		else $error("empty list beat malformed");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tdata[5:0] != 6'd0) && !m_tuser[1] ||
			m_tuser[0] && m_tuser[1] && (m_tdata[5:0] != 6'd0))
		else $error("element beat with zero size");

endmodule

bind sorted_unique_list_unit sul_checker u_sul_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for sorted_unique_list_unit: insert/delete beats with a
// running model of the sorted set, each readout beat checked in order.
// Depends on sul_pkg and the RTL of sorted_unique_list_unit.
module testbench;
	import sul_pkg::*;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_e;

	typedef struct packed {
		logic [5:0]         list_size;
		logic signed [31:0] element;
		logic               element_valid;
		logic               last;
		logic               overflow;
	} readout_t;

	localparam int IDLE_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic [0:0]  s_tuser;   // [0] op
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [5:0] list_size, [37:6] element, [39:38] zero
	logic [1:0]  m_tuser;   // [0] element_valid, [1] overflow
	logic        m_tlast;

	logic signed [31:0] list_vals[$];
	readout_t           expected_beats[$];
	int                 err_cnt;
	int                 beat_idx;
	int                 stall_cnt;
	int                 idle_cycles;
	bit                 idle_off;

	sorted_unique_list_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Update the sorted set and queue the readout beats it causes.
	function automatic void apply_list_op(op_e op, logic signed [31:0] val);
		int       pos;
		bit       present;
		bit       ovf;
		readout_t r;
		pos = 0;
		ovf = 1'b0;
		while (pos < list_vals.size() && list_vals[pos] < val)
			pos++;
		present = (pos < list_vals.size()) && (list_vals[pos] == val);
		if (op == OP_INSERT) begin
			if (!present) begin
				if (list_vals.size() >= CAPACITY)
					ovf = 1'b1;
				else
					list_vals.insert(pos, val);
			end
		end else if (present) begin
			list_vals.delete(pos);
		end
		if (list_vals.size() == 0) begin
			r = '{list_size: '0, element: '0, element_valid: 1'b0, last: 1'b1, overflow: ovf};
			expected_beats.push_back(r);
		end else begin
			foreach (list_vals[k]) begin
				r.list_size     = 6'(list_vals.size());
				r.element       = list_vals[k];
				r.element_valid = 1'b1;
				r.last          = (k == list_vals.size() - 1);
				r.overflow      = ovf;
				expected_beats.push_back(r);
			end
		end
	endfunction

	// Called just after a rising edge; valid is held across back-to-back beats.
	task automatic send_op(input op_e op, input logic signed [31:0] val);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		apply_list_op(op, val);
	endtask

	task automatic test_directed();
		idle_off = 1'b0;
		send_op(OP_DELETE, 32'sd5);
		send_op(OP_INSERT, 32'sd0);
		send_op(OP_INSERT, 32'sh8000_0000);
		send_op(OP_INSERT, 32'sh7fff_ffff);
		send_op(OP_INSERT, -32'sd1);
		send_op(OP_INSERT, 32'sd0);
		idle_off = 1'b1;
		send_op(OP_INSERT, 32'sh5555_5555);
		send_op(OP_INSERT, 32'shaaaa_aaaa);
		send_op(OP_DELETE, 32'sd7);
		send_op(OP_DELETE, 32'sh8000_0000);
		send_op(OP_DELETE, 32'sh7fff_ffff);
		idle_off = 1'b0;
		send_op(OP_DELETE, 32'sd0);
		send_op(OP_DELETE, -32'sd1);
		send_op(OP_DELETE, 32'sh5555_5555);
		send_op(OP_DELETE, 32'shaaaa_aaaa);
		send_op(OP_DELETE, 32'shaaaa_aaaa);
	endtask

	task automatic test_fill_overflow();
		idle_off = 1'b0;
		while (list_vals.size() < CAPACITY)
			send_op(OP_INSERT, $urandom());
		send_op(OP_INSERT, $urandom());
		send_op(OP_INSERT, 32'sh8000_0000);
		send_op(OP_INSERT, 32'sh7fff_ffff);
		send_op(OP_INSERT, list_vals[0]);
		send_op(OP_INSERT, list_vals[CAPACITY-1]);
		send_op(OP_INSERT, list_vals[$urandom_range(0, CAPACITY-1)]);
		send_op(OP_DELETE, list_vals[$urandom_range(0, CAPACITY-1)]);
		send_op(OP_INSERT, 32'sh8000_0000);
		send_op(OP_INSERT, $urandom());
		idle_off = 1'b1;
		while (list_vals.size() > 0) begin
			if ($urandom_range(0, 7) == 0)
				send_op(OP_DELETE, $urandom());
			else
				send_op(OP_DELETE, list_vals[$urandom_range(0, list_vals.size()-1)]);
		end
	endtask

	// Small value pool so duplicates, hits on delete and overflow are frequent.
	task automatic test_random_pool();
		logic signed [31:0] val_pool[40];
		int                 ins_pct;
		op_e                op;
		foreach (val_pool[i])
			val_pool[i] = $urandom();
		val_pool[0] = 32'sh8000_0000;
		val_pool[1] = 32'sh7fff_ffff;
		val_pool[2] = 32'sd0;
		val_pool[3] = -32'sd1;
		for (int n = 0; n < 200; n++) begin
			if (n % 25 == 0) begin
				ins_pct  = ((n / 25) % 2 == 0) ? 80 : 25;
				idle_off = ((n / 25) % 3 == 2);
			end
			op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
			send_op(op, val_pool[$urandom_range(0, 39)]);
		end
	endtask

	task automatic test_random_wide();
		op_e op;
		for (int n = 0; n < 130; n++) begin
			idle_off = ((n / 20) % 2 == 1);
			op = ($urandom_range(0, 99) < 60) ? OP_INSERT : OP_DELETE;
			if (op == OP_DELETE && list_vals.size() > 0 && $urandom_range(0, 9) < 7)
				send_op(op, list_vals[$urandom_range(0, list_vals.size()-1)]);
			else
				send_op(op, $urandom());
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		err_cnt   = 0;
		beat_idx  = 0;
		idle_off  = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_overflow();
		test_random_pool();
		test_random_wide();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		m_tready  = 1'b0;
		stall_cnt = 0;
		forever begin
			@(negedge clk);
			if (stall_cnt > 0) begin
				m_tready <= 1'b0;
				stall_cnt--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : chk_readout
		readout_t got;
		readout_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{list_size: m_tdata[5:0], element: m_tdata[37:6],
				element_valid: m_tuser[0], last: m_tlast, overflow: m_tuser[1]};
			if (expected_beats.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("beat %0d: unexpected, size=%0d elem=%0d vld=%b last=%b ovf=%b",
						beat_idx, got.list_size, got.element, got.element_valid,
						got.last, got.overflow);
			end else begin
				want = expected_beats.pop_front();
				if (got.list_size !== want.list_size || got.element !== want.element ||
						got.element_valid !== want.element_valid ||
						got.last !== want.last || got.overflow !== want.overflow) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display({"beat %0d: exp size=%0d elem=%0d vld=%b last=%b ovf=%b, ",
							"got size=%0d elem=%0d vld=%b last=%b ovf=%b"}, beat_idx,
							want.list_size, want.element, want.element_valid, want.last,
							want.overflow, got.list_size, got.element, got.element_valid,
							got.last, got.overflow);
				end
			end
			beat_idx++;
			stall_cnt = idle_off ? 0 : $urandom_range(0, 7);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat accepted in %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule
